@@ design/hcbd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the HTTP chunked body decoder.
// Used by every design file and by the checker; depends on nothing.
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [1:0] TRAILER_LEN = 2'd2;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END_OK  = 2'd1,
        KIND_END_ERR = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_in;
        logic       body_end;
    } t_in;

    typedef struct packed {
        logic [7:0] data_out;
        t_kind      kind;
        logic       last_of_run;
    } t_out;

    // Results produced by one accepted byte: num is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] num;
        t_out       first;
        t_out       second;
    } t_push;

endpackage

@@ design/http_chunked_body_decoder.sv @@
`timescale 1ns / 1ps
// Top level of the HTTP chunked body decoder.
// Depends on hcbd_pkg, hcbd_core and hcbd_outq.
//
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_stall     | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall   | o_out_data (t_out)
//
// A byte is decoded in the cycle it is accepted and its results are written to a
// four-entry queue; a result can be taken the cycle after. One byte per cycle while
// bytes give at most one result and the output is not stalled; the queue's single
// read port gives one result a cycle, so bytes that give two results slow the input.
// The input stalls when the queue holds more than two results. Reset is synchronous
// and clears the framing state and the queue at once.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hcbd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output hcbd_pkg::t_out o_out_data
);

    hcbd_pkg::t_push push;
    logic            full;
    logic            in_xfer;

    assign o_in_stall = full;
    assign in_xfer    = i_in_valid && !full;

    hcbd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_item   (i_in_data),
        .o_push   (push)
    );

    hcbd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_valid (o_out_valid),
        .o_full  (full),
        .o_item  (o_out_data)
    );

endmodule

@@ design/hcbd_core.sv @@
`timescale 1ns / 1ps
// Framing state machine: parses size lines, counts payload, skips trailers.
// Depends on hcbd_pkg; feeds its results to hcbd_outq.
module hcbd_core #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  hcbd_pkg::t_in       i_item,
    output hcbd_pkg::t_push     o_push
);

    typedef enum logic [1:0] {
        PH_LINE,
        PH_PAY,
        PH_SKIP,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        DP_SPACE,
        DP_DIGITS,
        DP_STOP
    } t_dphase;

    t_phase               r_phase, n_phase;
    t_dphase              r_dphase, n_dphase;
    logic [SIZE_BITS-1:0] r_acc, n_acc;
    logic [SIZE_BITS-1:0] r_rem, n_rem;
    logic [1:0]           r_skip, n_skip;
    logic                 r_prev_cr, n_prev_cr;
    logic                 r_ovf, n_ovf;

    logic [7:0]           b;
    logic                 hex_ok;
    logic [3:0]           hex_val;
    logic [SIZE_BITS-1:0] rem_dec;
    logic [1:0]           skip_dec;
    hcbd_pkg::t_push      push;

    assign b = i_item.data_in;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            hex_val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            hex_val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            hex_val = 4'(b - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign rem_dec  = (r_rem != '0) ? r_rem - {{(SIZE_BITS-1){1'b0}}, 1'b1} : r_rem;
    assign skip_dec = (r_skip != 2'd0) ? r_skip - 2'd1 : r_skip;

    always_comb begin
        n_phase   = r_phase;
        n_dphase  = r_dphase;
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_skip    = r_skip;
        n_prev_cr = r_prev_cr;
        n_ovf     = r_ovf;
        push      = '0;

        if (i_accept) begin
            case (r_phase)
                PH_LINE: begin
                    if (r_prev_cr && b == hcbd_pkg::BYTE_LF) begin
                        n_prev_cr = 1'b0;
                        if (r_ovf) begin
                            push.first.kind = hcbd_pkg::KIND_END_ERR;
                            push.num        = 2'd1;
                            n_phase         = PH_DONE;
                        end else if (r_acc == '0) begin
                            push.first.kind = hcbd_pkg::KIND_END_OK;
                            push.num        = 2'd1;
                            n_phase         = PH_DONE;
                        end else begin
                            n_rem   = r_acc;
                            n_phase = PH_PAY;
                        end
                    end else if (r_prev_cr) begin
                        // A lone CR is line text that is not a digit, so it ends the digits.
                        if (r_dphase != DP_STOP) begin
                            n_dphase = DP_STOP;
                        end
                        n_prev_cr = (b == hcbd_pkg::BYTE_CR);
                    end else if (b == hcbd_pkg::BYTE_CR) begin
                        n_prev_cr = 1'b1;
                    end else if (r_dphase != DP_STOP) begin
                        if (b == hcbd_pkg::BYTE_SEMI) begin
                            n_dphase = DP_STOP;
                        end else if (!(r_dphase == DP_SPACE && b == hcbd_pkg::BYTE_SPACE)) begin
                            if (!hex_ok) begin
                                n_dphase = DP_STOP;
                            end else begin
                                n_dphase = DP_DIGITS;
                                if (!r_ovf) begin
                                    if (r_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
                                        n_ovf = 1'b1;
                                    end else begin
                                        n_acc = {r_acc[SIZE_BITS-5:0], hex_val};
                                    end
                                end
                            end
                        end
                    end
                end
                PH_PAY: begin
                    push.first.data_out = b;
                    push.first.kind     = hcbd_pkg::KIND_PAYLOAD;
                    push.num            = 2'd1;
                    n_rem               = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_SKIP;
                        n_skip  = hcbd_pkg::TRAILER_LEN;
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 2'd0) begin
                        n_phase   = PH_LINE;
                        n_acc     = '0;
                        n_dphase  = DP_SPACE;
                        n_prev_cr = 1'b0;
                        n_ovf     = 1'b0;
                    end
                end
                default: begin
                end
            endcase

            if (i_item.body_end) begin
                if (n_phase == PH_PAY) begin
                    if (push.num == 2'd0) begin
                        push.first.kind = hcbd_pkg::KIND_END_ERR;
                        push.num        = 2'd1;
                    end else begin
                        push.second.kind = hcbd_pkg::KIND_END_ERR;
                        push.num         = 2'd2;
                    end
                end else if (n_phase == PH_LINE || n_phase == PH_SKIP) begin
                    if (push.num == 2'd0) begin
                        push.first.kind = hcbd_pkg::KIND_END_OK;
                        push.num        = 2'd1;
                    end else begin
                        push.second.kind = hcbd_pkg::KIND_END_OK;
                        push.num         = 2'd2;
                    end
                end
                n_phase   = PH_LINE;
                n_acc     = '0;
                n_dphase  = DP_SPACE;
                n_prev_cr = 1'b0;
                n_ovf     = 1'b0;
                n_rem     = '0;
                n_skip    = 2'd0;
            end

            if (push.num == 2'd1) begin
                push.first.last_of_run = 1'b1;
            end
            if (push.num == 2'd2) begin
                push.second.last_of_run = 1'b1;
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LINE;
            r_dphase  <= DP_SPACE;
            r_acc     <= '0;
            r_rem     <= '0;
            r_skip    <= 2'd0;
            r_prev_cr <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_dphase  <= n_dphase;
            r_acc     <= n_acc;
            r_rem     <= n_rem;
            r_skip    <= n_skip;
            r_prev_cr <= n_prev_cr;
            r_ovf     <= n_ovf;
        end
    end

endmodule

@@ design/hcbd_outq.sv @@
`timescale 1ns / 1ps
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on hcbd_pkg; written by hcbd_core.
module hcbd_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hcbd_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output hcbd_pkg::t_out  o_item
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    hcbd_pkg::t_out r_mem [DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_count, n_count;
    logic           pop;

    assign o_valid = (r_count != '0);
    // Room for two results must be there before a byte is taken.
    assign o_full  = (r_count > CW'(DEPTH - 2));
    assign o_item  = r_mem[r_rp];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wp    = r_wp + PW'(i_push.num);
        n_rp    = r_rp + PW'(pop);
        n_count = r_count + CW'(i_push.num) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wp + PW'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

@@ design/hcbd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the HTTP chunked body decoder, bound to the top level.
// Depends on hcbd_pkg and http_chunked_body_decoder.
module hcbd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input hcbd_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input hcbd_pkg::t_out o_out_data
);

    logic out_xfer;

    assign out_xfer = o_out_valid && !i_out_stall;

    // The result queue is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // An end mark is always the last result of its byte.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind != hcbd_pkg::KIND_PAYLOAD)
            |-> (o_out_data.last_of_run && o_out_data.data_out == 8'd0))
        else $error("end mark not last or carries data");

    // The partner of a non-last result was queued with it, so it is ready next cycle.
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !o_out_data.last_of_run) |=> o_out_valid)
        else $error("second result of a byte missing");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled input byte changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
